>>> src/lpr_pkg.sv
// shared constants and types for the line point rasterizer
// no dependencies
package lpr_pkg;

  // default coordinate width
  localparam int LPR_COORD_BITS = 5;
  // symbol width
  localparam int LPR_SYM_BITS = 8;
  // depth of the queue between front and back
  localparam int LPR_QUEUE_DEPTH = 2;

  // queue status seen by both sides
  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

endpackage

>>> src/lpr_queue.sv
// small request queue between the front and back parts
// depends on lpr_pkg
module lpr_queue import lpr_pkg::*; #(
  parameter int WIDTH = 8,
  parameter int DEPTH = LPR_QUEUE_DEPTH
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  logic [WIDTH-1:0] push_data,
  input  logic             pop,
  output logic [WIDTH-1:0] pop_data,
  output q_stat_t          stat
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int NW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [PW-1:0]    wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0]    rd_ptr_r, rd_ptr_nxt;
  logic [NW-1:0]    count_r, count_nxt;
  logic             do_push, do_pop;

  assign stat.full  = (count_r == NW'(DEPTH));
  assign stat.empty = (count_r == '0);
  assign do_push    = push && !stat.full;
  assign do_pop     = pop && !stat.empty;
  assign pop_data   = mem_r[rd_ptr_r];

  // pointer and fill count update
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PW'(DEPTH - 1)) ? '0 : wr_ptr_r + PW'(1);
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PW'(DEPTH - 1)) ? '0 : rd_ptr_r + PW'(1);
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + NW'(1);
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - NW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // storage
  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

>>> src/lpr_front.sv
// front part: takes line requests, finds the squared length and its floor root
// depends on lpr_pkg
module lpr_front import lpr_pkg::*; #(
  parameter int COORD_BITS = LPR_COORD_BITS
) (
  input  logic                                        clk,
  input  logic                                        rst_n,
  input  logic                                        in_valid,
  output logic                                        in_ready,
  input  logic [COORD_BITS-1:0]                       in_start_x,
  input  logic [COORD_BITS-1:0]                       in_start_y,
  input  logic [COORD_BITS-1:0]                       in_end_x,
  input  logic [COORD_BITS-1:0]                       in_end_y,
  input  logic [LPR_SYM_BITS-1:0]                     in_symbol,
  input  q_stat_t                                     q_stat,
  output logic                                        q_push,
  output logic [LPR_SYM_BITS+5*COORD_BITS:0]          q_data
);

  localparam int CW = COORD_BITS;
  localparam int LW = CW + 1;
  localparam int SW = 2 * CW + 1;
  localparam int KW = $clog2(LW);

  localparam logic [1:0] F_IDLE = 2'd0;
  localparam logic [1:0] F_ROOT = 2'd1;
  localparam logic [1:0] F_PUSH = 2'd2;

  logic [1:0]              state_r, state_nxt;
  logic [CW-1:0]           sx_r, sy_r, ex_r, ey_r;
  logic [LPR_SYM_BITS-1:0] sym_r;
  logic [SW-1:0]           sum_r;
  logic [LW-1:0]           root_r, root_nxt;
  logic [KW-1:0]           bit_r, bit_nxt;
  logic [CW-1:0]           dx, dy;
  logic [2*CW-1:0]         dx_sq, dy_sq;
  logic [LW-1:0]           cand;
  logic [2*LW-1:0]         cand_sq;
  logic                    accept;

  assign in_ready = (state_r == F_IDLE);
  assign accept   = in_valid && in_ready;

  // absolute differences and squared length
  assign dx    = (in_end_x >= in_start_x) ? in_end_x - in_start_x : in_start_x - in_end_x;
  assign dy    = (in_end_y >= in_start_y) ? in_end_y - in_start_y : in_start_y - in_end_y;
  assign dx_sq = dx * dx;
  assign dy_sq = dy * dy;

  // one root bit per cycle, msb first
  assign cand    = root_r | (LW'(1) << bit_r);
  assign cand_sq = cand * cand;

  always_comb begin
    state_nxt = state_r;
    root_nxt  = root_r;
    bit_nxt   = bit_r;
    unique case (state_r)
      F_IDLE: begin
        if (accept) begin
          state_nxt = F_ROOT;
          root_nxt  = '0;
          bit_nxt   = KW'(LW - 1);
        end
      end
      F_ROOT: begin
        if (cand_sq <= (2*LW)'(sum_r)) begin
          root_nxt = cand;
        end
        if (bit_r == '0) begin
          state_nxt = F_PUSH;
        end else begin
          bit_nxt = bit_r - KW'(1);
        end
      end
      F_PUSH: begin
        if (!q_stat.full) begin
          state_nxt = F_IDLE;
        end
      end
      default: begin
        state_nxt = F_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= F_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // request payload and root datapath
  always_ff @(posedge clk) begin
    root_r <= root_nxt;
    bit_r  <= bit_nxt;
    if (accept) begin
      sx_r  <= in_start_x;
      sy_r  <= in_start_y;
      ex_r  <= in_end_x;
      ey_r  <= in_end_y;
      sym_r <= in_symbol;
      sum_r <= SW'(dx_sq) + SW'(dy_sq);
    end
  end

  // hand the request and its root length to the queue
  assign q_push = (state_r == F_PUSH) && !q_stat.full;
  assign q_data = {sym_r, sx_r, sy_r, ex_r, ey_r, root_r};

  // the root handed on is the exact floor square root
  a_root_low: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == F_PUSH) |-> ((2*LW)'(root_r) * (2*LW)'(root_r) <= (2*LW)'(sum_r)))
    else $error("root too large");

  a_root_high: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == F_PUSH) |->
      (((2*LW+2)'(root_r) + (2*LW+2)'(1)) * ((2*LW+2)'(root_r) + (2*LW+2)'(1))
        > (2*LW+2)'(sum_r)))
    else $error("root too small");

endmodule

>>> src/lpr_back.sv
// back part: walks the points of one line with incremental quotient and remainder
// depends on lpr_pkg
module lpr_back import lpr_pkg::*; #(
  parameter int COORD_BITS = LPR_COORD_BITS
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  q_stat_t                             q_stat,
  input  logic [LPR_SYM_BITS+5*COORD_BITS:0]  q_data,
  output logic                                q_pop,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic [COORD_BITS-1:0]               out_point_x,
  output logic [COORD_BITS-1:0]               out_point_y,
  output logic [LPR_SYM_BITS-1:0]             out_point_symbol,
  output logic                                out_last_point
);

  localparam int CW = COORD_BITS;
  localparam int LW = CW + 1;
  localparam int RW = LW + 2;

  localparam logic B_IDLE = 1'b0;
  localparam logic B_RUN  = 1'b1;

  logic                    state_r, state_nxt;
  logic [LPR_SYM_BITS-1:0] sym_r;
  logic [CW-1:0]           ex_r, ey_r;
  logic [LW-1:0]           len_r, i_r;
  logic signed [CW:0]      dlx_r, dly_r;
  logic [CW-1:0]           qx_r, qy_r;
  logic signed [RW-1:0]    rx_r, ry_r;
  logic                    out_valid_r;
  logic [CW-1:0]           px_r, py_r;
  logic [LPR_SYM_BITS-1:0] psym_r;
  logic                    plast_r;
  logic [CW-1:0]           j_sx, j_sy, j_ex, j_ey;
  logic [LPR_SYM_BITS-1:0] j_sym;
  logic [LW-1:0]           j_len;
  logic                    take, emit, last_now;
  logic [CW+RW-1:0]        nx, ny;

  // add the step to the remainder and fix the quotient by at most one
  function automatic logic [CW+RW-1:0] step(input logic [CW-1:0] q,
                                            input logic signed [RW-1:0] r,
                                            input logic signed [CW:0] d,
                                            input logic [LW-1:0] len);
    logic signed [RW-1:0] s;
    logic signed [RW-1:0] l;
    l = $signed({2'b00, len});
    s = r + RW'(d);
    if (s >= l) begin
      return {q + CW'(1), s - l};
    end else if (s < 0) begin
      return {q - CW'(1), s + l};
    end
    return {q, s};
  endfunction

  assign {j_sym, j_sx, j_sy, j_ex, j_ey, j_len} = q_data;

  assign take     = !out_valid_r || out_ready;
  assign emit     = (state_r == B_RUN) && take;
  assign last_now = (i_r == len_r);
  assign q_pop    = (state_r == B_IDLE) && !q_stat.empty;
  assign nx       = step(qx_r, rx_r, dlx_r, len_r);
  assign ny       = step(qy_r, ry_r, dly_r, len_r);

  // line sequencer
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      B_IDLE: begin
        if (q_pop) begin
          state_nxt = B_RUN;
        end
      end
      B_RUN: begin
        if (emit && last_now) begin
          state_nxt = B_IDLE;
        end
      end
      default: begin
        state_nxt = B_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= B_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (emit) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // point walk: numerator = q*len + r, starting at start*len
  always_ff @(posedge clk) begin
    if (q_pop) begin
      sym_r <= j_sym;
      ex_r  <= j_ex;
      ey_r  <= j_ey;
      len_r <= j_len;
      i_r   <= '0;
      dlx_r <= $signed({1'b0, j_ex}) - $signed({1'b0, j_sx});
      dly_r <= $signed({1'b0, j_ey}) - $signed({1'b0, j_sy});
      qx_r  <= j_sx;
      qy_r  <= j_sy;
      rx_r  <= '0;
      ry_r  <= '0;
    end else if (emit) begin
      i_r            <= i_r + LW'(1);
      {qx_r, rx_r}   <= nx;
      {qy_r, ry_r}   <= ny;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (emit) begin
      px_r    <= qx_r;
      py_r    <= qy_r;
      psym_r  <= sym_r;
      plast_r <= last_now;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_point_x      = px_r;
  assign out_point_y      = py_r;
  assign out_point_symbol = psym_r;
  assign out_last_point   = plast_r;

  a_count: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == B_RUN) |-> (i_r <= len_r))
    else $error("point count past line length");

  a_rem: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == B_RUN) |->
      ((rx_r >= 0) && (ry_r >= 0) &&
       ((len_r == '0) || ((rx_r < $signed({2'b00, len_r})) &&
                          (ry_r < $signed({2'b00, len_r}))))))
    else $error("remainder out of range");

  a_end: assert property (@(posedge clk) disable iff (!rst_n)
    (emit && last_now) |-> ((qx_r == ex_r) && (qy_r == ey_r)))
    else $error("last point is not the end point");

endmodule

>>> src/line_point_rasterizer.sv
// line point rasterizer: front finds the line length, back emits its points
// depends on lpr_pkg, lpr_front, lpr_queue, lpr_back
// each request passes the front root search, the queue and the back walk in turn
// front finds one root bit per cycle; a new request waits until the last is pushed
// back emits L+1 points per line of length L, one a cycle when out_ready allows
// synchronous active-low reset empties the queue and the output register
module line_point_rasterizer import lpr_pkg::*; #(
  parameter int COORD_BITS = LPR_COORD_BITS
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_valid,
  output logic                    in_ready,
  input  logic [COORD_BITS-1:0]   in_start_x,
  input  logic [COORD_BITS-1:0]   in_start_y,
  input  logic [COORD_BITS-1:0]   in_end_x,
  input  logic [COORD_BITS-1:0]   in_end_y,
  input  logic [LPR_SYM_BITS-1:0] in_symbol,
  output logic                    out_valid,
  input  logic                    out_ready,
  output logic [COORD_BITS-1:0]   out_point_x,
  output logic [COORD_BITS-1:0]   out_point_y,
  output logic [LPR_SYM_BITS-1:0] out_point_symbol,
  output logic                    out_last_point
);

  localparam int JW = LPR_SYM_BITS + 5 * COORD_BITS + 1;

  q_stat_t         q_stat;
  logic            q_push, q_pop;
  logic [JW-1:0]   q_wdata, q_rdata;

  // request intake and length
  lpr_front #(.COORD_BITS(COORD_BITS)) u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_start_x (in_start_x),
    .in_start_y (in_start_y),
    .in_end_x   (in_end_x),
    .in_end_y   (in_end_y),
    .in_symbol  (in_symbol),
    .q_stat     (q_stat),
    .q_push     (q_push),
    .q_data     (q_wdata)
  );

  // decoupling queue
  lpr_queue #(.WIDTH(JW), .DEPTH(LPR_QUEUE_DEPTH)) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_data (q_wdata),
    .pop       (q_pop),
    .pop_data  (q_rdata),
    .stat      (q_stat)
  );

  // point generation
  lpr_back #(.COORD_BITS(COORD_BITS)) u_back (
    .clk              (clk),
    .rst_n            (rst_n),
    .q_stat           (q_stat),
    .q_data           (q_rdata),
    .q_pop            (q_pop),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_point_x      (out_point_x),
    .out_point_y      (out_point_y),
    .out_point_symbol (out_point_symbol),
    .out_last_point   (out_last_point)
  );

endmodule

>>> bench/lpr_checker.sv
`timescale 1ns / 1ps
// point stream checker for the line point rasterizer: predicts the points of every
// accepted line request and compares each emitted point field by field
// depends on lpr_pkg
module lpr_checker import lpr_pkg::*; #(
  parameter int COORD_BITS = LPR_COORD_BITS
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_valid,
  input  logic                    in_ready,
  input  logic [COORD_BITS-1:0]   in_start_x,
  input  logic [COORD_BITS-1:0]   in_start_y,
  input  logic [COORD_BITS-1:0]   in_end_x,
  input  logic [COORD_BITS-1:0]   in_end_y,
  input  logic [LPR_SYM_BITS-1:0] in_symbol,
  input  logic                    out_valid,
  input  logic                    out_ready,
  input  logic [COORD_BITS-1:0]   out_point_x,
  input  logic [COORD_BITS-1:0]   out_point_y,
  input  logic [LPR_SYM_BITS-1:0] out_point_symbol,
  input  logic                    out_last_point,
  output int                      fail_count,
  output int                      points_left,
  output int                      points_seen
);

  typedef struct packed {
    logic [COORD_BITS-1:0]   x;
    logic [COORD_BITS-1:0]   y;
    logic [LPR_SYM_BITS-1:0] sym;
    logic                    last;
  } point_t;

  // points still owed by the block, oldest first
  point_t pending_points[$];

  // floor square root of the squared length
  function automatic int unsigned length_root(input int unsigned n);
    int unsigned r;
    r = 0;
    while ((r + 1) * (r + 1) <= n) r++;
    return r;
  endfunction

  // expand one line request into the points it must produce
  task automatic plot_line(input int unsigned sx, input int unsigned sy,
                           input int unsigned ex, input int unsigned ey,
                           input logic [LPR_SYM_BITS-1:0] sym);
    int unsigned dx;
    int unsigned dy;
    int unsigned len;
    point_t p;
    dx = (ex > sx) ? ex - sx : sx - ex;
    dy = (ey > sy) ? ey - sy : sy - ey;
    len = length_root(dx * dx + dy * dy);
    p.sym = sym;
    // zero length: the start point alone
    if (len == 0) begin
      p.x = COORD_BITS'(sx);
      p.y = COORD_BITS'(sy);
      p.last = 1'b1;
      pending_points.push_back(p);
    end else begin
      for (int unsigned i = 0; i <= len; i++) begin
        p.x = COORD_BITS'((i * ex + (len - i) * sx) / len);
        p.y = COORD_BITS'((i * ey + (len - i) * sy) / len);
        p.last = (i == len);
        pending_points.push_back(p);
      end
    end
  endtask

  task automatic check_field(input string name, input int unsigned want,
                             input int unsigned got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      fail_count++;
    end
  endtask

  // sample both channels at the rising edge
  always @(posedge clk) begin
    point_t p;
    if (!rst_n) begin
      pending_points.delete();
    end else begin
      if (in_valid && in_ready)
        plot_line(in_start_x, in_start_y, in_end_x, in_end_y, in_symbol);
      if (out_valid && out_ready) begin
        points_seen++;
        if (pending_points.size() == 0) begin
          $error("point with no line pending: x=%0d y=%0d symbol=%0d last=%0b",
                 out_point_x, out_point_y, out_point_symbol, out_last_point);
          fail_count++;
        end else begin
          p = pending_points.pop_front();
          check_field("point_x", p.x, out_point_x);
          check_field("point_y", p.y, out_point_y);
          check_field("point_symbol", p.sym, out_point_symbol);
          check_field("last_point", p.last, out_last_point);
        end
      end
    end
    points_left = pending_points.size();
  end

endmodule

>>> bench/tb_top.sv
`timescale 1ns / 1ps
// top of the line point rasterizer bench: clock, reset, line requests and
// point stalls; depends on lpr_pkg, line_point_rasterizer and lpr_checker
module tb_top;
  import lpr_pkg::*;

  localparam int CB          = LPR_COORD_BITS;
  localparam int COORD_MAX   = (1 << CB) - 1;
  localparam int QUIET_LIMIT = 4000;
  localparam int PHASE_LINES = 46;

  logic                    clk;
  logic                    rst_n;
  logic                    in_valid;
  logic                    in_ready;
  logic [CB-1:0]           in_start_x;
  logic [CB-1:0]           in_start_y;
  logic [CB-1:0]           in_end_x;
  logic [CB-1:0]           in_end_y;
  logic [LPR_SYM_BITS-1:0] in_symbol;
  logic                    out_valid;
  logic                    out_ready;
  logic [CB-1:0]           out_point_x;
  logic [CB-1:0]           out_point_y;
  logic [LPR_SYM_BITS-1:0] out_point_symbol;
  logic                    out_last_point;

  int fail_count;
  int points_left;
  int points_seen;
  int idle_pct;
  int stall_pct;
  int lines_sent;
  int quiet_cycles;
  logic in_took;

  line_point_rasterizer #(.COORD_BITS(CB)) dut (.*);

  lpr_checker #(.COORD_BITS(CB)) point_check (.*);

  // clock
  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // request acceptance seen at the last rising edge
  always @(posedge clk) in_took <= in_valid && in_ready;

  // receiver stalls
  always @(negedge clk) out_ready = ($urandom_range(99) >= stall_pct);

  // watchdog on cycles with no transfer on either channel
  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles == QUIET_LIMIT) begin
      $display("line_point_rasterizer: mismatch");
      $finish;
    end
  end

  // one line request, with random sender gaps in front of it
  task automatic send_line(input int sx, input int sy, input int ex, input int ey,
                           input int sym);
    while ($urandom_range(99) < idle_pct) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    in_valid   = 1'b1;
    in_start_x = CB'(sx);
    in_start_y = CB'(sy);
    in_end_x   = CB'(ex);
    in_end_y   = CB'(ey);
    in_symbol  = LPR_SYM_BITS'(sym);
    do @(negedge clk); while (!in_took);
    lines_sent++;
  endtask

  // hold off requests until every owed point has come out
  task automatic wait_drained();
    in_valid = 1'b0;
    while (points_left != 0) @(negedge clk);
  endtask

  function automatic int clamp_coord(input int v);
    return (v < 0) ? 0 : (v > COORD_MAX) ? COORD_MAX : v;
  endfunction

  // random line, mostly shaped: zero length, axis aligned, short, corner to corner
  task automatic send_random_line();
    int sx, sy, ex, ey;
    int shape;
    sx = $urandom_range(COORD_MAX);
    sy = $urandom_range(COORD_MAX);
    ex = $urandom_range(COORD_MAX);
    ey = $urandom_range(COORD_MAX);
    shape = $urandom_range(99);
    if (shape < 15) begin
      ex = sx;
      ey = sy;
    end else if (shape < 25) begin
      ey = sy;
    end else if (shape < 35) begin
      ex = sx;
    end else if (shape < 55) begin
      ex = clamp_coord(sx + $urandom_range(6) - 3);
      ey = clamp_coord(sy + $urandom_range(6) - 3);
    end else if (shape < 65) begin
      sx = $urandom_range(1) * COORD_MAX;
      sy = $urandom_range(1) * COORD_MAX;
      ex = $urandom_range(1) * COORD_MAX;
      ey = $urandom_range(1) * COORD_MAX;
    end
    send_line(sx, sy, ex, ey, $urandom_range(255));
  endtask

  initial begin
    int idle_mix[5];
    int stall_mix[5];
    idle_mix  = '{0, 47, 0, 12, 0};
    stall_mix = '{0, 0, 47, 12, 0};
    rst_n      = 1'b0;
    in_valid   = 1'b0;
    in_start_x = '0;
    in_start_y = '0;
    in_end_x   = '0;
    in_end_y   = '0;
    in_symbol  = '0;
    out_ready  = 1'b0;
    idle_pct   = 0;
    stall_pct  = 0;
    lines_sent = 0;
    repeat (12) @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    // directed: extremes, zero length, longest line, axis aligned, unit lines
    send_line(0, 0, 0, 0, 8'h00);
    send_line(COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX, 8'hFF);
    send_line(0, 0, COORD_MAX, COORD_MAX, 8'h2A);
    send_line(COORD_MAX, COORD_MAX, 0, 0, 8'hAA);
    send_line(0, COORD_MAX, COORD_MAX, 0, 8'h55);
    send_line(COORD_MAX, 0, 0, COORD_MAX, 8'h23);
    send_line(0, 5, COORD_MAX, 5, 8'h2D);
    send_line(17, COORD_MAX, 17, 0, 8'h7C);
    send_line(3, 4, 0, 0, 8'h80);
    send_line(0, 0, 1, 0, 8'h01);
    send_line(1, 1, 2, 2, 8'h7F);
    send_line(COORD_MAX, 0, COORD_MAX - 1, 1, 8'hFE);
    send_line(9, 12, 9, 12, 8'h40);
    send_line(0, 0, COORD_MAX, 1, 8'h2E);

    // sender waits for the block to empty
    wait_drained();

    // random lines under each idle and stall mix
    for (int ph = 0; ph < 5; ph++) begin
      idle_pct  = idle_mix[ph];
      stall_pct = stall_mix[ph];
      for (int n = 0; n < PHASE_LINES; n++) send_random_line();
      if (ph == 2) wait_drained();
    end

    // drain and let the pipeline settle
    in_valid  = 1'b0;
    idle_pct  = 0;
    stall_pct = 0;
    while (points_left != 0) @(negedge clk);
    repeat (20) @(negedge clk);
    if (points_left != 0)
      $error("%0d expected points never came out", points_left);

    $display("covered %0d line requests (extremes, zero length, random shapes) under",
             lines_sent);
    $display("idle and stall mixes, %0d points compared", points_seen);
    if (fail_count == 0 && points_left == 0) begin
      $display("line_point_rasterizer: match");
    end else begin
      $display("line_point_rasterizer: mismatch");
    end
    $finish;
  end

endmodule
